// ===== rtl/core/utf8_ld_pkg.sv =====
// Package for the lenient UTF-8 decoder: code point constants and the
// per-byte burst descriptor passed from the decode stage to the emitter.
// No dependencies.
`timescale 1ns / 1ps

package utf8_ld_pkg;

    localparam int CP_W    = 21;
    localparam int CNT_W   = 3;   // results per byte: 0..4
    localparam int IDX_W   = 2;   // result index within a burst: 0..3
    localparam int HELD_W  = 2;
    localparam int LEN_W   = 3;

    localparam logic [CP_W-1:0] REPL_CHAR = 21'h00FFFD;
    localparam logic [CP_W-1:0] MAX_CP    = 21'h10FFFF;
    localparam logic [7:0]      ASCII_MAX = 8'h7F;
    localparam logic [1:0]      CONT_TAG  = 2'b10;

    localparam logic [LEN_W-1:0] LEN_TWO   = 3'd2;
    localparam logic [LEN_W-1:0] LEN_THREE = 3'd3;
    localparam logic [LEN_W-1:0] LEN_FOUR  = 3'd4;

    // Results for one byte: count replacements around at most one main
    // result, which sits at index main_idx when has_main is set.
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [IDX_W-1:0] main_idx;
        logic             has_main;
        logic [CP_W-1:0]  main_cp;
        logic             main_rep;
        logic             fin;
    } burst_t;

endpackage

// ===== rtl/core/utf8_ld_in_if.sv =====
// Byte input channel of the lenient UTF-8 decoder: valid/ready plus payload.
// No dependencies.
`timescale 1ns / 1ps

interface utf8_ld_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       is_final;

    modport source (output valid, output data_byte, output is_final, input ready);
    modport sink   (input valid, input data_byte, input is_final, output ready);
endinterface

// ===== rtl/core/utf8_ld_out_if.sv =====
// Code point output channel of the lenient UTF-8 decoder.
// No dependencies.
`timescale 1ns / 1ps

interface utf8_ld_out_if;
    logic        valid;
    logic        ready;
    logic [20:0] char_code;
    logic        replaced;
    logic        run_end;
    logic        text_end;

    modport source (output valid, output char_code, output replaced,
                    output run_end, output text_end, input ready);
    modport sink   (input valid, input char_code, input replaced,
                    input run_end, input text_end, output ready);
endinterface

// ===== rtl/core/utf8_ld_decode.sv =====
// Decode stage: holds the pending sequence state and turns each byte into a
// registered burst descriptor. Depends on utf8_ld_pkg and utf8_ld_in_if.
`timescale 1ns / 1ps

module utf8_ld_decode (
    input  logic                clk,
    input  logic                rst_n,
    utf8_ld_in_if.sink          raw,
    output utf8_ld_pkg::burst_t burst,
    output logic                burst_valid,
    input  logic                burst_pop
);
    import utf8_ld_pkg::*;

    logic [HELD_W-1:0] held_reg, held_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [CP_W-1:0]   val_reg, val_next;
    logic              burst_valid_reg;
    burst_t            burst_reg;
    burst_t            desc;

    logic              accept;
    logic              is_cont;
    logic              take_lead;
    logic [CP_W-1:0]   cont_val;
    logic [LEN_W-1:0]  held_inc;
    logic [HELD_W-1:0] n_pre;
    logic [HELD_W-1:0] held_mid;
    logic [LEN_W-1:0]  len_mid;
    logic [CP_W-1:0]   val_mid;
    logic              has_main;
    logic [CP_W-1:0]   main_cp;
    logic              main_rep;
    logic [HELD_W-1:0] n_post;

    assign raw.ready = !burst_valid_reg || burst_pop;
    assign accept    = raw.valid && raw.ready;

    assign is_cont  = (raw.data_byte[7:6] == CONT_TAG);
    assign cont_val = {val_reg[CP_W-7:0], raw.data_byte[5:0]};
    assign held_inc = {1'b0, held_reg} + LEN_W'(1);

    always_comb
    begin
        take_lead = 1'b1;
        n_pre     = '0;
        held_mid  = held_reg;
        len_mid   = len_reg;
        val_mid   = val_reg;
        has_main  = 1'b0;
        main_cp   = REPL_CHAR;
        main_rep  = 1'b1;

        if (held_reg != '0)
        begin
            if (is_cont)
            begin
                take_lead = 1'b0;
                if (held_inc >= len_reg)
                begin
                    has_main = 1'b1;
                    if (cont_val > MAX_CP)
                    begin
                        main_cp  = REPL_CHAR;
                        main_rep = 1'b1;
                    end
                    else
                    begin
                        main_cp  = cont_val;
                        main_rep = 1'b0;
                    end
                    held_mid = '0;
                    len_mid  = '0;
                    val_mid  = '0;
                end
                else
                begin
                    held_mid = held_inc[HELD_W-1:0];
                    val_mid  = cont_val;
                end
            end
            else
            begin
                // broken sequence: one replacement per held byte, then relead
                n_pre    = held_reg;
                held_mid = '0;
                len_mid  = '0;
                val_mid  = '0;
            end
        end

        if (take_lead)
        begin
            if (raw.data_byte <= ASCII_MAX)
            begin
                has_main = 1'b1;
                main_cp  = {13'd0, raw.data_byte};
                main_rep = 1'b0;
            end
            else if (raw.data_byte[7:5] == 3'b110)
            begin
                held_mid = HELD_W'(1);
                len_mid  = LEN_TWO;
                val_mid  = {16'd0, raw.data_byte[4:0]};
            end
            else if (raw.data_byte[7:4] == 4'b1110)
            begin
                held_mid = HELD_W'(1);
                len_mid  = LEN_THREE;
                val_mid  = {17'd0, raw.data_byte[3:0]};
            end
            else if (raw.data_byte[7:3] == 5'b11110)
            begin
                held_mid = HELD_W'(1);
                len_mid  = LEN_FOUR;
                val_mid  = {18'd0, raw.data_byte[2:0]};
            end
            else
            begin
                has_main = 1'b1;
                main_cp  = REPL_CHAR;
                main_rep = 1'b1;
            end
        end

        // end of text: flush whatever is still held
        if (raw.is_final)
        begin
            n_post    = held_mid;
            held_next = '0;
            len_next  = '0;
            val_next  = '0;
        end
        else
        begin
            n_post    = '0;
            held_next = held_mid;
            len_next  = len_mid;
            val_next  = val_mid;
        end

        desc.count    = {1'b0, n_pre} + {2'd0, has_main} + {1'b0, n_post};
        desc.main_idx = n_pre;
        desc.has_main = has_main;
        desc.main_cp  = main_cp;
        desc.main_rep = main_rep;
        desc.fin      = raw.is_final;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg        <= '0;
            len_reg         <= '0;
            val_reg         <= '0;
            burst_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                held_reg <= held_next;
                len_reg  <= len_next;
                val_reg  <= val_next;
                // a byte that only extends a sequence makes no burst
                burst_valid_reg <= (desc.count != '0);
            end
            else if (burst_pop)
            begin
                burst_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            burst_reg <= desc;
        end
    end

    assign burst       = burst_reg;
    assign burst_valid = burst_valid_reg;

endmodule

// ===== rtl/core/utf8_ld_emit.sv =====
// Emitter: walks a burst descriptor one result per beat into the output
// register. Depends on utf8_ld_pkg and utf8_ld_out_if.
`timescale 1ns / 1ps

module utf8_ld_emit (
    input  logic                clk,
    input  logic                rst_n,
    input  utf8_ld_pkg::burst_t burst,
    input  logic                burst_valid,
    output logic                burst_pop,
    utf8_ld_out_if.source       decoded
);
    import utf8_ld_pkg::*;

    logic [IDX_W-1:0] idx_reg;
    logic             out_valid_reg;
    logic [CP_W-1:0]  cp_reg;
    logic             rep_reg;
    logic             run_end_reg;
    logic             text_end_reg;

    logic             load;
    logic             is_main;
    logic             last;
    logic             rep;

    assign load    = burst_valid && (!out_valid_reg || decoded.ready);
    assign is_main = burst.has_main && (idx_reg == burst.main_idx);
    assign last    = (({1'b0, idx_reg} + CNT_W'(1)) == burst.count);
    assign rep     = !is_main || burst.main_rep;

    assign burst_pop = load && last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                idx_reg       <= last ? '0 : idx_reg + IDX_W'(1);
            end
            else if (decoded.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cp_reg       <= rep ? REPL_CHAR : burst.main_cp;
            rep_reg      <= rep;
            run_end_reg  <= last;
            text_end_reg <= last && burst.fin;
        end
    end

    assign decoded.valid     = out_valid_reg;
    assign decoded.char_code = cp_reg;
    assign decoded.replaced  = rep_reg;
    assign decoded.run_end   = run_end_reg;
    assign decoded.text_end  = text_end_reg;

endmodule

// ===== rtl/core/utf8_lenient_decoder.sv =====
// Top level of the lenient UTF-8 decoder: decode stage feeding the emitter.
// Depends on utf8_ld_pkg, utf8_ld_in_if, utf8_ld_out_if and both stages.
//
//   channel   dir  payload                                    beat
//   raw       in   data_byte[7:0], is_final                   one byte
//   decoded   out  char_code[20:0], replaced, run_end,        one code point
//                  text_end
//
// A byte with one result (or none) is taken every cycle while decoded does not
// stall; a code point passes the burst register, then the output register.
// A byte with k results, k up to 4, holds raw while the emitter walks
// the burst register one result per beat.
// Reset clears the pending sequence and both valid flags; no clearing pass.
// A stall on decoded backs up into raw through the burst register.
`timescale 1ns / 1ps

module utf8_lenient_decoder (
    input  logic          clk,
    input  logic          rst_n,
    utf8_ld_in_if.sink    raw,
    utf8_ld_out_if.source decoded
);
    import utf8_ld_pkg::*;

    burst_t burst;
    logic   burst_valid;
    logic   burst_pop;

    utf8_ld_decode u_decode (
        .clk         (clk),
        .rst_n       (rst_n),
        .raw         (raw),
        .burst       (burst),
        .burst_valid (burst_valid),
        .burst_pop   (burst_pop)
    );

    utf8_ld_emit u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .burst       (burst),
        .burst_valid (burst_valid),
        .burst_pop   (burst_pop),
        .decoded     (decoded)
    );

endmodule

// ===== tb/tb_utf8_lenient_decoder.sv =====
// Self-checking bench for utf8_lenient_decoder: random and directed byte texts
// go in, each decoded code point is checked against an in-bench decoder.
// Depends on utf8_ld_pkg, utf8_ld_in_if, utf8_ld_out_if and the decoder RTL.
`timescale 1ns / 1ps

module tb_utf8_lenient_decoder;

    import utf8_ld_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [7:0] data;
        logic       fin;
    } raw_beat_t;

    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic            rep;
        logic            run_end;
        logic            text_end;
    } cp_result_t;

    logic clk;
    logic rst_n;

    utf8_ld_in_if  raw_if();
    utf8_ld_out_if dec_if();

    utf8_lenient_decoder dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .raw     (raw_if),
        .decoded (dec_if)
    );

    raw_beat_t  pending_bytes[$];
    cp_result_t expected_cps[$];

    // decoder state mirrored by the bench
    int              held_cnt;
    int              seq_len;
    logic [CP_W-1:0] acc_cp;

    int bytes_queued;
    int bytes_accepted;
    int cps_seen;
    int repl_seen;
    int texts_ended;
    int err_cnt;
    int cycle_cnt;

    raw_beat_t next_beat;
    int        burst_left;
    int        gap_left;
    logic [7:0] stall_pat;
    int         pat_age;

    function automatic cp_result_t mk_cp(input logic [CP_W-1:0] cp, input logic rep);
        cp_result_t r;
        r.cp       = cp;
        r.rep      = rep;
        r.run_end  = 1'b0;
        r.text_end = 1'b0;
        return r;
    endfunction

    task automatic push_byte(input logic [7:0] b, input logic fin);
        raw_beat_t beat;
        beat.data = b;
        beat.fin  = fin;
        pending_bytes.push_back(beat);
        bytes_queued++;
    endtask

    // Work out every code point one accepted byte produces.
    task automatic decode_byte(input logic [7:0] b, input logic fin);
        cp_result_t run[$];
        logic       as_lead;
        as_lead = 1'b1;
        if (held_cnt != 0)
        begin
            if (b[7:6] == CONT_TAG)
            begin
                as_lead = 1'b0;
                acc_cp  = {acc_cp[CP_W-7:0], b[5:0]};
                if (held_cnt + 1 >= seq_len)
                begin
                    if (acc_cp > MAX_CP)
                        run.push_back(mk_cp(REPL_CHAR, 1'b1));
                    else
                        run.push_back(mk_cp(acc_cp, 1'b0));
                    held_cnt = 0;
                    seq_len  = 0;
                    acc_cp   = '0;
                end
                else
                begin
                    held_cnt++;
                end
            end
            else
            begin
                // broken sequence: one replacement per held byte, then re-decode
                repeat (held_cnt) run.push_back(mk_cp(REPL_CHAR, 1'b1));
                held_cnt = 0;
                seq_len  = 0;
                acc_cp   = '0;
            end
        end
        if (as_lead)
        begin
            if (b <= ASCII_MAX)
            begin
                run.push_back(mk_cp({13'd0, b}, 1'b0));
            end
            else if (b[7:5] == 3'b110)
            begin
                held_cnt = 1;
                seq_len  = LEN_TWO;
                acc_cp   = {16'd0, b[4:0]};
            end
            else if (b[7:4] == 4'b1110)
            begin
                held_cnt = 1;
                seq_len  = LEN_THREE;
                acc_cp   = {17'd0, b[3:0]};
            end
            else if (b[7:3] == 5'b11110)
            begin
                held_cnt = 1;
                seq_len  = LEN_FOUR;
                acc_cp   = {18'd0, b[2:0]};
            end
            else
            begin
                run.push_back(mk_cp(REPL_CHAR, 1'b1));
            end
        end
        if (fin)
        begin
            repeat (held_cnt) run.push_back(mk_cp(REPL_CHAR, 1'b1));
            held_cnt = 0;
            seq_len  = 0;
            acc_cp   = '0;
        end
        if (run.size() > 0)
        begin
            run[run.size()-1].run_end  = 1'b1;
            run[run.size()-1].text_end = fin;
        end
        foreach (run[i])
            expected_cps.push_back(run[i]);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d bytes accepted of %0d, %0d code points pending",
                     $time, bytes_accepted, bytes_queued, expected_cps.size());
            $display("tb_utf8_lenient_decoder: errors");
            $finish;
        end
    end

    // Sender: bursts of random length separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_if.valid     <= 1'b0;
            raw_if.data_byte <= 8'd0;
            raw_if.is_final  <= 1'b0;
            burst_left       <= 1;
            gap_left         <= 0;
        end
        else if (!raw_if.valid || raw_if.ready)
        begin
            if (gap_left > 0 || pending_bytes.size() == 0)
            begin
                raw_if.valid <= 1'b0;
                if (gap_left > 0)
                    gap_left <= gap_left - 1;
            end
            else
            begin
                next_beat = pending_bytes.pop_front();
                raw_if.valid     <= 1'b1;
                raw_if.data_byte <= next_beat.data;
                raw_if.is_final  <= next_beat.fin;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
                end
                else
                begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    // Receiver: rotate a stall pattern, reload it each time pat_age wraps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dec_if.ready <= 1'b0;
            stall_pat    <= 8'hFF;
            pat_age      <= 0;
        end
        else
        begin
            if (pat_age == 47)
            begin
                pat_age   <= 0;
                stall_pat <= ($urandom_range(0, 3) == 0) ? 8'hFF
                                                         : 8'($urandom_range(1, 255));
            end
            else
            begin
                pat_age   <= pat_age + 1;
                stall_pat <= {stall_pat[6:0], stall_pat[7]};
            end
            dec_if.ready <= stall_pat[0];
        end
    end

    // Monitor: predict on each byte beat, check each code point beat.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (raw_if.valid && raw_if.ready)
            begin
                bytes_accepted++;
                decode_byte(raw_if.data_byte, raw_if.is_final);
            end
            if (dec_if.valid && dec_if.ready)
            begin
                cps_seen++;
                if (dec_if.replaced)
                    repl_seen++;
                if (dec_if.text_end)
                    texts_ended++;
                if (expected_cps.size() == 0)
                begin
                    err_cnt++;
                    $display("%0t: code point %h rep=%b run_end=%b text_end=%b, none expected",
                             $time, dec_if.char_code, dec_if.replaced,
                             dec_if.run_end, dec_if.text_end);
                end
                else if (dec_if.char_code != expected_cps[0].cp
                         || dec_if.replaced != expected_cps[0].rep
                         || dec_if.run_end  != expected_cps[0].run_end
                         || dec_if.text_end != expected_cps[0].text_end)
                begin
                    err_cnt++;
                    $display("%0t: mismatch, expected cp=%h rep=%b run_end=%b text_end=%b",
                             $time, expected_cps[0].cp, expected_cps[0].rep,
                             expected_cps[0].run_end, expected_cps[0].text_end);
                    $display("%0t:           actual   cp=%h rep=%b run_end=%b text_end=%b",
                             $time, dec_if.char_code, dec_if.replaced,
                             dec_if.run_end, dec_if.text_end);
                    void'(expected_cps.pop_front());
                end
                else
                begin
                    void'(expected_cps.pop_front());
                end
            end
        end
    end

    initial
    begin
        logic [7:0] text_bytes[$];
        logic [7:0] seq[4];
        int         n_chars;
        int         kind;
        int         len;
        int         seq_n;

        rst_n            = 1'b0;
        held_cnt         = 0;
        seq_len          = 0;
        acc_cp           = '0;
        bytes_queued     = 0;
        bytes_accepted   = 0;
        cps_seen         = 0;
        repl_seen        = 0;
        texts_ended      = 0;
        err_cnt          = 0;
        cycle_cnt        = 0;

        // ASCII extremes
        push_byte(8'h00, 1'b0);
        push_byte(8'h7F, 1'b0);
        // genuine U+FFFD decodes with replaced low
        push_byte(8'hEF, 1'b0); push_byte(8'hBF, 1'b0); push_byte(8'hBD, 1'b0);
        // four-byte sequence
        push_byte(8'hF0, 1'b0); push_byte(8'h9F, 1'b0);
        push_byte(8'h98, 1'b0); push_byte(8'h80, 1'b0);
        // invalid leads: stray continuation, then the top byte
        push_byte(8'h80, 1'b0);
        push_byte(8'hFF, 1'b0);
        // overlong form and a surrogate pass through
        push_byte(8'hC0, 1'b0); push_byte(8'h80, 1'b0);
        push_byte(8'hED, 1'b0); push_byte(8'hA0, 1'b0); push_byte(8'h80, 1'b0);
        // above 0x10FFFF
        push_byte(8'hF4, 1'b0); push_byte(8'h90, 1'b0);
        push_byte(8'h80, 1'b0); push_byte(8'h80, 1'b0);
        // broken sequence: three held bytes, then ASCII re-decoded
        push_byte(8'hF0, 1'b0); push_byte(8'h9F, 1'b0);
        push_byte(8'h98, 1'b0); push_byte(8'h41, 1'b0);
        // text end with held bytes: flush, new lead, flush again
        push_byte(8'hF0, 1'b0); push_byte(8'h9F, 1'b0);
        push_byte(8'h98, 1'b0); push_byte(8'hE2, 1'b1);

        // Random texts, mostly well-formed sequences with random payload bits.
        while (bytes_queued < 370)
        begin
            text_bytes.delete();
            n_chars = $urandom_range(1, 12);
            repeat (n_chars)
            begin
                kind = $urandom_range(0, 19);
                if (kind < 3)
                begin
                    seq[0] = 8'($urandom_range(0, 255));
                    seq_n  = 1;
                end
                else
                begin
                    len = $urandom_range(1, 4);
                    case (len)
                        1:       seq[0] = 8'($urandom_range(0, 127));
                        2:       seq[0] = 8'hC0 + 8'($urandom_range(0, 31));
                        3:       seq[0] = 8'hE0 + 8'($urandom_range(0, 15));
                        default: seq[0] = 8'hF0 + 8'($urandom_range(0, 7));
                    endcase
                    for (int i = 1; i < len; i++)
                        seq[i] = {CONT_TAG, 6'($urandom_range(0, 63))};
                    // drop the tail now and then to break the sequence
                    if (kind < 6 && len > 1)
                        seq_n = $urandom_range(1, len - 1);
                    else
                        seq_n = len;
                end
                for (int i = 0; i < seq_n; i++)
                    text_bytes.push_back(seq[i]);
            end
            for (int i = 0; i < text_bytes.size(); i++)
                push_byte(text_bytes[i],
                          i == text_bytes.size() - 1 && $urandom_range(0, 4) != 0);
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (bytes_accepted < bytes_queued)
            @(posedge clk);
        while (expected_cps.size() != 0)
            @(posedge clk);
        // keep running to catch stray beats
        repeat (10) @(posedge clk);

        $display("%0d bytes in, %0d code points out (%0d replacements), %0d texts closed",
                 bytes_accepted, cps_seen, repl_seen, texts_ended);
        if (err_cnt == 0)
            $display("tb_utf8_lenient_decoder: clean");
        else
            $display("tb_utf8_lenient_decoder: errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/utf8_ld_pkg.sv
rtl/core/utf8_ld_in_if.sv
rtl/core/utf8_ld_out_if.sv
rtl/core/utf8_ld_decode.sv
rtl/core/utf8_ld_emit.sv
rtl/core/utf8_lenient_decoder.sv
tb/tb_utf8_lenient_decoder.sv
